// File: rtl/core/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared sizes and types for the sorted interval table.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int BOUND_W     = 32;
   localparam int ENTRY_W     = 2 * BOUND_W;
   localparam int OUT_CNT_W   = 7;
   localparam int REQ_DATA_W  = 3 * BOUND_W;
   localparam int RSP_DATA_W  = 16;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic [BOUND_W-1:0] upper;
      logic [BOUND_W-1:0] lower;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: rtl/core/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sit_ctrl.sv
// ----------------------------------------------------------------------------
// sit_ctrl
// Sequencer for inserts (shift walk) and lookups (binary search) over the RAM.
// ----------------------------------------------------------------------------
module sit_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_kind,
   input  logic [sit_pkg::BOUND_W-1:0]  req_low_bound,
   input  logic [sit_pkg::BOUND_W-1:0]  req_high_bound,
   input  logic [sit_pkg::BOUND_W-1:0]  req_probe_value,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_found,
   output logic [sit_pkg::OUT_CNT_W-1:0] rsp_entry_count,
   output logic                         rsp_rejected,
   output sit_pkg::mem_req_type         mem_req,
   input  sit_pkg::entry_type           mem_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_PUT,
      S_LK_RD,
      S_LK_CMP,
      S_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [sit_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [sit_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [sit_pkg::CNT_W-1:0]       lo_ff, lo_in;
   logic [sit_pkg::CNT_W-1:0]       hix_ff, hix_in;   // exclusive upper end
   logic [sit_pkg::IDX_W-1:0]       mid_ff, mid_in;
   logic [sit_pkg::BOUND_W-1:0]     lb_ff, lb_in;
   logic [sit_pkg::BOUND_W-1:0]     ub_ff, ub_in;
   logic [sit_pkg::BOUND_W-1:0]     probe_ff, probe_in;
   logic                            res_found_ff, res_found_in;
   logic                            res_rej_ff, res_rej_in;
   logic                            inc_ff, inc_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_rej_ff, rsp_rej_in;
   logic [sit_pkg::OUT_CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic [sit_pkg::CNT_W:0]         mid_sum;
   logic [sit_pkg::CNT_W-1:0]       count_next;
   logic                            in_range;
   logic                            above;

   assign req_tready = (state_ff == S_IDLE);

   assign in_range = ($signed(probe_ff) >= $signed(mem_rd_data.lower)) &&
                     ($signed(probe_ff) <= $signed(mem_rd_data.upper));
   assign above    = ($signed(probe_ff) > $signed(mem_rd_data.upper));
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hix_ff} - (sit_pkg::CNT_W + 1)'(1);
   assign count_next = sit_pkg::CNT_W'(count_ff + sit_pkg::CNT_W'(inc_ff));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hix_in       = hix_ff;
      mid_in       = mid_ff;
      lb_in        = lb_ff;
      ub_in        = ub_ff;
      probe_in     = probe_ff;
      res_found_in = res_found_ff;
      res_rej_in   = res_rej_ff;
      inc_in       = inc_ff;
      rsp_found_in = rsp_found_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               lb_in        = req_low_bound;
               ub_in        = req_high_bound;
               probe_in     = req_probe_value;
               res_found_in = 1'b0;
               res_rej_in   = 1'b0;
               inc_in       = 1'b0;
               if (req_kind == sit_pkg::KIND_INSERT) begin
                  if (count_ff == sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH)) begin
                     res_rej_in = 1'b1;
                     state_in   = S_DONE;
                  end else if (count_ff == '0) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = '0;
                     mem_req.wr_data = '{upper: req_high_bound, lower: req_low_bound};
                     inc_in          = 1'b1;
                     state_in        = S_DONE;
                  end else begin
                     pos_in          = sit_pkg::IDX_W'(count_ff);
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = sit_pkg::IDX_W'(count_ff - sit_pkg::CNT_W'(1));
                     state_in        = S_INS_CMP;
                  end
               end else begin
                  lo_in    = '0;
                  hix_in   = count_ff;
                  state_in = S_LK_RD;
               end
            end
         end
         S_INS_CMP: begin
            // read data is entry pos-1; move it up while its lower bound is greater
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if ($signed(mem_rd_data.lower) > $signed(lb_ff)) begin
               mem_req.wr_data = mem_rd_data;
               pos_in          = pos_ff - sit_pkg::IDX_W'(1);
               if (pos_ff == sit_pkg::IDX_W'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pos_ff - sit_pkg::IDX_W'(2);
               end
            end else begin
               mem_req.wr_data = '{upper: ub_ff, lower: lb_ff};
               inc_in          = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_INS_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = '{upper: ub_ff, lower: lb_ff};
            inc_in          = 1'b1;
            state_in        = S_DONE;
         end
         S_LK_RD: begin
            if (lo_ff >= hix_ff) begin
               state_in = S_DONE;
            end else begin
               mid_in          = sit_pkg::IDX_W'(mid_sum >> 1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sit_pkg::IDX_W'(mid_sum >> 1);
               state_in        = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            if (in_range) begin
               res_found_in = 1'b1;
               state_in     = S_DONE;
            end else begin
               if (above) begin
                  lo_in = sit_pkg::CNT_W'(mid_ff) + sit_pkg::CNT_W'(1);
               end else begin
                  hix_in = sit_pkg::CNT_W'(mid_ff);
               end
               state_in = S_LK_RD;
            end
         end
         S_DONE: begin
            // load the output register once the previous beat has gone
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_rej_in   = res_rej_ff;
               rsp_cnt_in   = sit_pkg::OUT_CNT_W'(count_next);
               count_in     = count_next;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      hix_ff       <= hix_in;
      mid_ff       <= mid_in;
      lb_ff        <= lb_in;
      ub_ff        <= ub_in;
      probe_ff     <= probe_in;
      res_found_ff <= res_found_in;
      res_rej_ff   <= res_rej_in;
      inc_ff       <= inc_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_entry_count = rsp_cnt_ff;

endmodule

// File: rtl/core/sorted_interval_table.sv
// ----------------------------------------------------------------------------
// sorted_interval_table
// Table of signed intervals kept in order of lower bound, with insert and
// binary-search lookup.
// ----------------------------------------------------------------------------
// Each request beat is an insert or a lookup and yields exactly one response
// beat. The intervals live in one RAM with a single, registered read port,
// and the block works on one request at a time. During an insert the shift
// walk reads one entry and writes it one place up in each cycle, while its
// lower bound is greater than the new one. A full table rejects an insert.
// Each lookup probe is a RAM read, then a compare, and a lookup makes at
// most ceil(log2(TABLE_DEPTH + 1)) probes. The response register lets the
// next request in while a response still waits. Stored bounds are undefined
// after reset; only entries below the count are ever read, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module sorted_interval_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: low_bound [31:0], high_bound [63:32], probe_value [95:64]
   input  logic [sit_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: kind [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: found [0], entry_count [7:1], rejected [8], zero [15:9]
   output logic [sit_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   sit_pkg::mem_req_type            mem_req;
   sit_pkg::entry_type              mem_rd_data;
   logic                            rsp_found;
   logic                            rsp_rejected;
   logic [sit_pkg::OUT_CNT_W-1:0]   rsp_entry_count;

   sit_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_kind        (req_tuser),
      .req_low_bound   (req_tdata[sit_pkg::BOUND_W-1:0]),
      .req_high_bound  (req_tdata[2*sit_pkg::BOUND_W-1:sit_pkg::BOUND_W]),
      .req_probe_value (req_tdata[3*sit_pkg::BOUND_W-1:2*sit_pkg::BOUND_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_found       (rsp_found),
      .rsp_entry_count (rsp_entry_count),
      .rsp_rejected    (rsp_rejected),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data)
   );

   sit_ram #(
      .WIDTH (sit_pkg::ENTRY_W),
      .DEPTH (sit_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {
      (sit_pkg::RSP_DATA_W - sit_pkg::OUT_CNT_W - 2)'(0),
      rsp_rejected,
      rsp_entry_count,
      rsp_found
   };

endmodule

// File: rtl/core/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level checks for the sorted interval table, bound to the top level.
// ----------------------------------------------------------------------------
module sit_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sit_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // one request in flight: busy straight after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous still in work");

   a_found_xor_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[8]))
      else $error("found and rejected both set");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] <= 7'(sit_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind sorted_interval_table sit_checker u_sit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/sorted_interval_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_interval_table_tb
// Self-checking bench for the sorted interval table. Insert and lookup beats
// are streamed in with random gaps while the response side applies random
// back-pressure. Every response is checked against a shadow copy of the
// table kept inside the bench. The directed opening covers the empty table,
// bound extremes, equal lower bounds and inverted intervals. The random part
// fills the table to capacity and then keeps pushing inserts that must be
// rejected.
// ----------------------------------------------------------------------------
module sorted_interval_table_tb;

   localparam int CALM_TAIL      = 120;
   localparam int RANDOM_OPS     = 1330;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic signed [sit_pkg::BOUND_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [sit_pkg::BOUND_W-1:0] S32_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic                               kind;
      logic signed [sit_pkg::BOUND_W-1:0] low_bound;
      logic signed [sit_pkg::BOUND_W-1:0] high_bound;
      logic signed [sit_pkg::BOUND_W-1:0] probe_value;
   } table_op_type;

   typedef struct {
      logic                          found;
      logic [sit_pkg::OUT_CNT_W-1:0] entry_count;
      logic                          rejected;
   } table_reply_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sit_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = sit_pkg::KIND_INSERT;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sit_pkg::RSP_DATA_W-1:0] rsp_tdata;

   table_op_type    op_queue[$];
   table_reply_type reply_queue[$];
   table_op_type    op_in_flight;

   // stimulus-side record of inserted bounds, used to aim lookups
   logic signed [sit_pkg::BOUND_W-1:0] known_low[$];
   logic signed [sit_pkg::BOUND_W-1:0] known_high[$];

   // shadow table
   logic signed [sit_pkg::BOUND_W-1:0] shadow_lower[sit_pkg::TABLE_DEPTH];
   logic signed [sit_pkg::BOUND_W-1:0] shadow_upper[sit_pkg::TABLE_DEPTH];
   int                                 shadow_count = 0;

   int req_gap     = 0;
   int rsp_stall   = 0;
   int idle_cycles = 0;
   int mismatches  = 0;

   sorted_interval_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Applies one operation to the shadow table and returns the reply it owes.
   function automatic table_reply_type table_step(table_op_type op);
      table_reply_type r;
      int              pos;
      int              lo;
      int              hi;
      int              mid;
      r.found    = 1'b0;
      r.rejected = 1'b0;
      if (op.kind == sit_pkg::KIND_INSERT) begin
         if (shadow_count >= sit_pkg::TABLE_DEPTH) begin
            r.rejected = 1'b1;
         end else begin
            pos = shadow_count;
            // strictly greater only, so equal lower bounds stay in arrival order
            while (pos > 0 && shadow_lower[pos-1] > op.low_bound) begin
               shadow_lower[pos] = shadow_lower[pos-1];
               shadow_upper[pos] = shadow_upper[pos-1];
               pos--;
            end
            shadow_lower[pos] = op.low_bound;
            shadow_upper[pos] = op.high_bound;
            shadow_count++;
         end
      end else begin
         lo = 0;
         hi = shadow_count - 1;
         while (lo <= hi && !r.found) begin
            mid = (lo + hi) / 2;
            if (op.probe_value >= shadow_lower[mid] && op.probe_value <= shadow_upper[mid])
               r.found = 1'b1;
            else if (op.probe_value > shadow_upper[mid])
               lo = mid + 1;
            else
               hi = mid - 1;
         end
      end
      r.entry_count = sit_pkg::OUT_CNT_W'(shadow_count);
      return r;
   endfunction

   function automatic logic signed [sit_pkg::BOUND_W-1:0] corner_value();
      case ($urandom_range(0, 3))
         0:       return S32_MIN;
         1:       return S32_MAX;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   task automatic push_op(input logic kind, input logic signed [sit_pkg::BOUND_W-1:0] lb,
                          input logic signed [sit_pkg::BOUND_W-1:0] ub,
                          input logic signed [sit_pkg::BOUND_W-1:0] probe);
      table_op_type op;
      op.kind        = kind;
      op.low_bound   = lb;
      op.high_bound  = ub;
      op.probe_value = probe;
      op_queue.push_back(op);
      if (kind == sit_pkg::KIND_INSERT) begin
         known_low.push_back(lb);
         known_high.push_back(ub);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            reply_queue.push_back(table_step(op_in_flight));
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (op_queue.size() != 0) begin
               op_in_flight = op_queue.pop_front();
               req_tdata  <= {op_in_flight.probe_value, op_in_flight.high_bound,
                              op_in_flight.low_bound};
               req_tuser  <= op_in_flight.kind;
               req_tvalid <= 1'b1;
               if (op_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      table_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               $error("response beat with no request outstanding: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = reply_queue.pop_front();
               if (rsp_tdata[0] !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[7:1] !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count,
                         rsp_tdata[7:1]);
                  mismatches++;
               end
               if (rsp_tdata[8] !== want.rejected) begin
                  $error("rejected: expected %0d, got %0d", want.rejected, rsp_tdata[8]);
                  mismatches++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (op_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
               rsp_stall = $urandom_range(1, 8);
         end
      end
   end

   // watchdog: cycles without a beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic signed [sit_pkg::BOUND_W-1:0] op_lb;
      logic signed [sit_pkg::BOUND_W-1:0] op_ub;
      logic signed [sit_pkg::BOUND_W-1:0] op_probe;
      logic [63:0]                        r64;
      longint                             span;
      int                                 k;

      // empty table
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd0);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, S32_MIN);
      // equal lower bounds, extremes, an inverted interval
      push_op(sit_pkg::KIND_INSERT, 32'sd0, 32'sd10, $urandom);
      push_op(sit_pkg::KIND_INSERT, 32'sd0, 32'sd20, $urandom);
      push_op(sit_pkg::KIND_INSERT, S32_MIN, S32_MIN + 5, $urandom);
      push_op(sit_pkg::KIND_INSERT, S32_MAX - 3, S32_MAX, $urandom);
      push_op(sit_pkg::KIND_INSERT, 32'sd100, 32'sd50, $urandom);
      push_op(sit_pkg::KIND_INSERT, -32'sd1000, -32'sd900, $urandom);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, S32_MIN);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, S32_MAX);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, S32_MAX - 4);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd0);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd15);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd20);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd21);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd75);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, 32'sd100);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, -32'sd950);
      push_op(sit_pkg::KIND_LOOKUP, $urandom, $urandom, -32'sd1);

      // about one insert in four: the table fills early, later inserts bounce
      for (int n = 0; n < RANDOM_OPS; n++) begin
         op_lb    = $urandom;
         op_ub    = $urandom;
         op_probe = $urandom;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
               0, 1: ;
               7: if (known_low.size() != 0) begin
                  op_lb = known_low[$urandom_range(0, known_low.size() - 1)];
                  op_ub = op_lb + $urandom_range(0, 100);
               end
               8: begin
                  op_lb = $urandom_range(0, 4000) - 2000;
                  op_ub = op_lb - $urandom_range(1, 30);
               end
               9: begin
                  op_lb = corner_value();
                  op_ub = corner_value();
               end
               default: begin
                  op_lb = $urandom_range(0, 4000) - 2000;
                  op_ub = op_lb + $urandom_range(0, 60);
               end
            endcase
            push_op(sit_pkg::KIND_INSERT, op_lb, op_ub, op_probe);
         end else begin
            if (known_low.size() != 0 && $urandom_range(0, 9) < 6) begin
               k = $urandom_range(0, known_low.size() - 1);
               span = longint'(known_high[k]) - longint'(known_low[k]) + 1;
               case ($urandom_range(0, 3))
                  0: op_probe = known_low[k] - 1;
                  1: op_probe = known_high[k] + 1;
                  default: begin
                     if (span > 0) begin
                        r64 = {$urandom, $urandom};
                        op_probe = 32'(longint'(known_low[k]) + longint'(r64 % 64'(span)));
                     end else begin
                        op_probe = known_low[k];
                     end
                  end
               endcase
            end else if ($urandom_range(0, 1) == 0) begin
               op_probe = $urandom_range(0, 4200) - 2100;
            end
            push_op(sit_pkg::KIND_LOOKUP, op_lb, op_ub, op_probe);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || req_tvalid || reply_queue.size() != 0)
         @(negedge clock);
      repeat (sit_pkg::TABLE_DEPTH + 16) @(posedge clock);

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
